// ===== hw/rtl/sxf_pkg.sv =====
`default_nettype none

package sxf_pkg;

    // item kind codes
    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DRAW  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    // field widths
    localparam int COORD_W  = 8;
    localparam int ROFF_W   = 4;
    localparam int BYTE_W   = 8;
    localparam int PIXELS_W = 64;

    // wrapped row plus row offset reaches at most 63 + 15
    localparam int ROW_W = 7;

    // reciprocal multiply for the coordinate wrap
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W      = 32;

endpackage

`default_nettype wire

// ===== hw/rtl/sxf_ram.sv =====
`default_nettype none

module sxf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sprite_xor_framebuffer.sv =====
// channel  | valid       | stall       | payload
// ---------+-------------+-------------+----------------------------------------------
// request  | i_in_valid  | o_in_stall  | i_kind i_pos_x i_pos_y i_row_offset
//          |             |             | i_sprite_byte i_last_row
// result   | o_out_valid | i_out_stall | o_collision o_sprite_done o_row_pixels
//
// Every request passes through these steps in order: accept (coordinate quotients), row RAM read,
// then XOR / write back and load of the result register.
// The single framebuffer RAM read-modify-write sets these steps; no new request is taken until they end.
// Clear drops all per-row valid bits at once; an invalid row reads as zero.
// Reset is synchronous, active low, and leaves the screen blank (no RAM sweep).
// A stalled result holds the block in its write-back step until it is taken.
`default_nettype none

module sprite_xor_framebuffer #(
    parameter int SCREEN_WIDTH  = 64,
    parameter int SCREEN_HEIGHT = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [sxf_pkg::KIND_W-1:0]      i_kind,
    input  wire logic [sxf_pkg::COORD_W-1:0]     i_pos_x,
    input  wire logic [sxf_pkg::COORD_W-1:0]     i_pos_y,
    input  wire logic [sxf_pkg::ROFF_W-1:0]      i_row_offset,
    input  wire logic [sxf_pkg::BYTE_W-1:0]      i_sprite_byte,
    input  wire logic                            i_last_row,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic                                 o_collision,
    output logic                                 o_sprite_done,
    output logic      [sxf_pkg::PIXELS_W-1:0]    o_row_pixels
);

    import sxf_pkg::*;

    localparam int AW      = $clog2(SCREEN_HEIGHT);
    localparam int RECIP_X = (1 << RECIP_SHIFT) / SCREEN_WIDTH + 1;
    localparam int RECIP_Y = (1 << RECIP_SHIFT) / SCREEN_HEIGHT + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WRITE
    } t_state;

    t_state r_state;

    // control registers
    logic                     r_out_valid;
    logic                     r_coll;
    logic [SCREEN_HEIGHT-1:0] r_valid;

    // request registers
    logic [KIND_W-1:0]  r_kind;
    logic [COORD_W-1:0] r_px;
    logic [COORD_W-1:0] r_py;
    logic [COORD_W-1:0] r_qx;
    logic [COORD_W-1:0] r_qy;
    logic [ROFF_W-1:0]  r_roff;
    logic [BYTE_W-1:0]  r_sbyte;
    logic               r_last;
    logic [ROW_W-1:0]   r_x0;
    logic [ROW_W-1:0]   r_row;

    // result registers
    logic                r_out_coll;
    logic                r_out_done;
    logic [PIXELS_W-1:0] r_out_pixels;

    logic                    w_in_acc;
    logic [PROD_W-1:0]       w_px_prod;
    logic [PROD_W-1:0]       w_py_prod;
    logic [15:0]             w_xmod;
    logic [15:0]             w_ymod;
    logic [ROW_W-1:0]        w_row;
    logic                    w_go;
    logic                    w_in_range;
    logic [AW-1:0]           w_idx;
    logic [SCREEN_WIDTH-1:0] w_rdata;
    logic [SCREEN_WIDTH-1:0] w_cur;
    logic [SCREEN_WIDTH-1:0] w_put;
    logic [ROW_W-1:0]        w_col;
    logic                    w_we;
    logic                    w_coll_base;
    logic                    n_coll;
    logic [PIXELS_W-1:0]     n_pixels;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // quotients by reciprocal multiply, exact for 8-bit coordinates
    assign w_px_prod = PROD_W'(i_pos_x) * PROD_W'(RECIP_X);
    assign w_py_prod = PROD_W'(i_pos_y) * PROD_W'(RECIP_Y);

    // remainders and target row
    assign w_xmod = 16'(r_px) - 16'(r_qx) * 16'(SCREEN_WIDTH);
    assign w_ymod = 16'(r_py) - 16'(r_qy) * 16'(SCREEN_HEIGHT);
    assign w_row  = (r_kind == KIND_DRAW) ? (w_ymod[ROW_W-1:0] + ROW_W'(r_roff))
                                          : w_ymod[ROW_W-1:0];

    // write-back step may finish once the result register is free
    assign w_go       = (r_state == S_WRITE) && (!r_out_valid || !i_out_stall);
    assign w_in_range = (r_row < ROW_W'(SCREEN_HEIGHT));
    assign w_idx      = r_row[AW-1:0];
    assign w_cur      = (w_in_range && r_valid[w_idx]) ? w_rdata : '0;

    // sprite row placed at its columns, clipped at the right edge
    always_comb begin
        w_put = '0;
        w_col = '0;
        for (int i = 0; i < BYTE_W; i++) begin
            w_col = r_x0 + ROW_W'(i);
            if (w_col < ROW_W'(SCREEN_WIDTH) && r_sbyte[BYTE_W-1-i]) begin
                w_put = w_put | (SCREEN_WIDTH'(1) << w_col);
            end
        end
    end

    assign w_we = w_go && (r_kind == KIND_DRAW) && w_in_range;

    // collision restarts on the first sprite row
    assign w_coll_base = (r_roff == '0) ? 1'b0 : r_coll;
    assign n_coll      = (r_kind == KIND_DRAW)
                         ? (w_coll_base || (w_in_range && |(w_cur & w_put)))
                         : r_coll;
    assign n_pixels    = (r_kind == KIND_READ) ? PIXELS_W'(w_cur) : '0;

    sxf_ram #(
        .WIDTH (SCREEN_WIDTH),
        .DEPTH (SCREEN_HEIGHT)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_idx),
        .i_wdata (w_cur ^ w_put),
        .i_re    (r_state == S_READ),
        .i_raddr (w_row[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // state, valid bits and result handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_coll      <= 1'b0;
            r_valid     <= '0;
        end else begin
            // result valid rises on write-back and falls once taken
            if (w_go) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    if (w_go) begin
                        r_state <= S_IDLE;
                        r_coll  <= n_coll;
                        if (r_kind == KIND_CLEAR) begin
                            r_valid <= '0;
                        end else if (w_we) begin
                            r_valid[w_idx] <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_kind  <= i_kind;
            r_px    <= i_pos_x;
            r_py    <= i_pos_y;
            r_qx    <= w_px_prod[RECIP_SHIFT +: COORD_W];
            r_qy    <= w_py_prod[RECIP_SHIFT +: COORD_W];
            r_roff  <= i_row_offset;
            r_sbyte <= i_sprite_byte;
            r_last  <= i_last_row;
        end
        if (r_state == S_READ) begin
            r_x0  <= w_xmod[ROW_W-1:0];
            r_row <= w_row;
        end
        if (w_go) begin
            r_out_coll   <= n_coll;
            r_out_done   <= (r_kind == KIND_DRAW) && r_last;
            r_out_pixels <= n_pixels;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_collision   = r_out_coll;
    assign o_sprite_done = r_out_done;
    assign o_row_pixels  = r_out_pixels;

    // an accepted request blocks the next one
    a_acc_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_in_stall)
        else $error("request accepted while busy");

    // finishing write-back loads the result and frees the input
    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go |=> (o_out_valid && r_state == S_IDLE))
        else $error("write-back did not produce a result");

    // the RAM is only written for rows on screen
    a_write_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_row < ROW_W'(SCREEN_HEIGHT) && r_kind == KIND_DRAW))
        else $error("framebuffer write outside the screen");

    // a finished sprite never carries scan-out pixels
    a_done_pixels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_sprite_done) |-> (o_row_pixels == '0))
        else $error("sprite result carries row pixels");

endmodule

`default_nettype wire

// ===== bench/tb_sprite_xor_framebuffer.sv =====
`timescale 1ns / 100ps

module tb_sprite_xor_framebuffer;
    import sxf_pkg::*;

    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic [PIXELS_W-1:0] ROW_MASK =
        (SCREEN_WIDTH >= PIXELS_W) ? '1 : ((64'd1 << SCREEN_WIDTH) - 64'd1);
    localparam int RANDOM_ITEMS  = 1120;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int STUCK_LIMIT   = 2000;

    typedef struct packed {
        logic                collision;
        logic                sprite_done;
        logic [PIXELS_W-1:0] row_pixels;
    } t_frame_result;

    // dut ports
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [KIND_W-1:0]   i_kind = KIND_CLEAR;
    logic [COORD_W-1:0]  i_pos_x = '0;
    logic [COORD_W-1:0]  i_pos_y = '0;
    logic [ROFF_W-1:0]   i_row_offset = '0;
    logic [BYTE_W-1:0]   i_sprite_byte = '0;
    logic                i_last_row = 1'b0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic                o_collision;
    logic                o_sprite_done;
    logic [PIXELS_W-1:0] o_row_pixels;

    // predicted screen contents and collision latch
    logic [PIXELS_W-1:0] screen_rows [SCREEN_HEIGHT];
    logic                collide_latch;
    t_frame_result       pending_results [$];

    int  error_count;
    int  request_count;
    int  result_count;
    int  stuck_cycles;
    bit  sender_burst;
    bit  receiver_eager;
    bit  hold_request;

    sprite_xor_framebuffer #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_row_offset  (i_row_offset),
        .i_sprite_byte (i_sprite_byte),
        .i_last_row    (i_last_row),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_collision   (o_collision),
        .o_sprite_done (o_sprite_done),
        .o_row_pixels  (o_row_pixels)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // apply one request to the screen copy and return the result it yields
    function automatic t_frame_result predict_frame_result(
        input logic [KIND_W-1:0]  kind,
        input logic [COORD_W-1:0] pos_x,
        input logic [COORD_W-1:0] pos_y,
        input logic [ROFF_W-1:0]  row_offset,
        input logic [BYTE_W-1:0]  sprite_byte,
        input logic               last_row
    );
        t_frame_result       res;
        int                  x0;
        int                  row;
        logic [PIXELS_W-1:0] put;
        res = '0;
        case (kind)
            KIND_CLEAR: begin
                for (int r = 0; r < SCREEN_HEIGHT; r++)
                    screen_rows[r] = '0;
            end
            KIND_DRAW: begin
                x0  = int'(pos_x) % SCREEN_WIDTH;
                row = (int'(pos_y) % SCREEN_HEIGHT) + int'(row_offset);
                // a new sprite restarts the collision latch
                if (row_offset == '0)
                    collide_latch = 1'b0;
                if (row < SCREEN_HEIGHT) begin
                    put = '0;
                    for (int i = 0; i < 8; i++) begin
                        if (x0 + i < SCREEN_WIDTH && sprite_byte[7-i])
                            put[x0+i] = 1'b1;
                    end
                    if ((screen_rows[row] & put) != '0)
                        collide_latch = 1'b1;
                    screen_rows[row] = (screen_rows[row] ^ put) & ROW_MASK;
                end
                res.sprite_done = last_row;
            end
            KIND_READ: begin
                res.row_pixels = screen_rows[int'(pos_y) % SCREEN_HEIGHT] & ROW_MASK;
            end
            default: begin
            end
        endcase
        res.collision = collide_latch;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [PIXELS_W-1:0] exp_val,
                                   input logic [PIXELS_W-1:0] got_val);
        $display("ERROR at %0t, result %0d: %s expected %h got %h",
                 $time, result_count, what, exp_val, got_val);
        error_count++;
    endtask

    // offer one request, wait for it to be taken, then predict its result
    task automatic send_request(
        input logic [KIND_W-1:0]  kind,
        input logic [COORD_W-1:0] pos_x,
        input logic [COORD_W-1:0] pos_y,
        input logic [ROFF_W-1:0]  row_offset,
        input logic [BYTE_W-1:0]  sprite_byte,
        input logic               last_row
    );
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_kind        <= kind;
        i_pos_x       <= pos_x;
        i_pos_y       <= pos_y;
        i_row_offset  <= row_offset;
        i_sprite_byte <= sprite_byte;
        i_last_row    <= last_row;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(
            predict_frame_result(kind, pos_x, pos_y, row_offset, sprite_byte, last_row));
        request_count++;
    endtask

    // one sprite row with random don't-care fields left out
    task automatic send_draw(input logic [COORD_W-1:0] pos_x, input logic [COORD_W-1:0] pos_y,
                             input logic [ROFF_W-1:0] row_offset,
                             input logic [BYTE_W-1:0] sprite_byte, input logic last_row);
        send_request(KIND_DRAW, pos_x, pos_y, row_offset, sprite_byte, last_row);
    endtask

    // read with random values in the fields a read ignores
    task automatic send_read(input logic [COORD_W-1:0] pos_y);
        send_request(KIND_READ, COORD_W'($urandom), pos_y, ROFF_W'($urandom),
                     BYTE_W'($urandom), 1'($urandom));
    endtask

    // drop valid and wait until every predicted result has been taken
    task automatic wait_for_results;
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // result side: random stall per result, plus one long hold-off on request
    initial begin
        int wait_cycles;
        @(posedge i_rst_n);
        forever begin
            if (hold_request) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end else begin
                wait_cycles = receiver_eager ? 0 : $urandom_range(0, 15);
                if (wait_cycles > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (wait_cycles) @(posedge i_clk);
                end
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // compare each taken result with the oldest prediction
    always @(posedge i_clk) begin
        t_frame_result exp_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            result_count++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, row_pixels", '0, o_row_pixels);
            end else begin
                exp_res = pending_results.pop_front();
                if (o_collision !== exp_res.collision)
                    report_mismatch("collision", PIXELS_W'(exp_res.collision),
                                    PIXELS_W'(o_collision));
                if (o_sprite_done !== exp_res.sprite_done)
                    report_mismatch("sprite_done", PIXELS_W'(exp_res.sprite_done),
                                    PIXELS_W'(o_sprite_done));
                if (o_row_pixels !== exp_res.row_pixels)
                    report_mismatch("row_pixels", exp_res.row_pixels, o_row_pixels);
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("TIMEOUT at %0t: no handshake for %0d cycles", $time, STUCK_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // screen must read blank after reset
    task automatic test_blank_after_reset;
        send_read(8'd0);
        send_read(8'd255);
    endtask

    // two-row sprite at the origin, then read it back
    task automatic test_basic_draw;
        send_draw(8'd0, 8'd0, 4'd0, 8'hFF, 1'b0);
        send_draw(8'd0, 8'd0, 4'd1, 8'h81, 1'b1);
        send_read(8'd0);
        send_read(8'd1);
    endtask

    // overlapping sprite erases lit pixels; later rows keep the flag
    task automatic test_collision;
        send_draw(8'd4, 8'd0, 4'd0, 8'hF0, 1'b0);
        send_draw(8'd4, 8'd0, 4'd1, 8'h00, 1'b1);
        send_read(8'd0);
        // fresh sprite on blank pixels drops the flag again
        send_draw(8'd16, 8'd10, 4'd0, 8'h3C, 1'b1);
    endtask

    // right and bottom edges clip, start coordinates wrap
    task automatic test_clipping;
        send_draw(8'd60, 8'd5, 4'd0, 8'hFF, 1'b1);
        send_draw(8'd255, 8'd6, 4'd0, 8'hFF, 1'b1);
        send_draw(8'd200, 8'd7, 4'd0, 8'hA5, 1'b1);
        send_draw(8'd3, 8'd255, 4'd1, 8'hFF, 1'b0);
        send_draw(8'd3, 8'd31, 4'd15, 8'hFF, 1'b1);
        send_read(8'd5);
        send_read(8'd6);
        send_read(8'd71);
    endtask

    // unused kind is ignored; clear blanks the screen but keeps the flag
    task automatic test_clear_and_unused;
        send_draw(8'd60, 8'd5, 4'd0, 8'h80, 1'b1);
        send_request(KIND_UNUSED, 8'hFF, 8'hFF, 4'hF, 8'hFF, 1'b1);
        send_request(KIND_CLEAR, COORD_W'($urandom), COORD_W'($urandom), ROFF_W'($urandom),
                     BYTE_W'($urandom), 1'($urandom));
        send_read(8'd5);
        send_read(8'd0);
    endtask

    // receiver holds off long while requests keep coming, then full drain
    task automatic test_backpressure;
        hold_request = 1'b1;
        sender_burst = 1'b1;
        for (int n = 0; n < 40; n++) begin
            if (n % 4 == 3)
                send_read(COORD_W'($urandom));
            else
                send_draw(COORD_W'($urandom), COORD_W'($urandom), ROFF_W'(n % 4),
                          BYTE_W'($urandom), n % 4 == 2);
        end
        sender_burst = 1'b0;
        wait_for_results();
    endtask

    // mostly well-formed sprites and reads, some broken and ignored requests, a few clears
    task automatic test_random_traffic;
        int stop_at;
        int pick;
        int rows;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        stop_at = request_count + RANDOM_ITEMS;
        while (request_count < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                rows = $urandom_range(1, 16);
                sx   = COORD_W'($urandom);
                sy   = COORD_W'($urandom);
                for (int r = 0; r < rows; r++)
                    send_draw(sx, sy, ROFF_W'(r), BYTE_W'($urandom), r == rows - 1);
            end else if (pick < 75) begin
                send_read(COORD_W'($urandom));
            end else if (pick < 79) begin
                // scan-out of the whole screen
                for (int r = 0; r < SCREEN_HEIGHT; r++)
                    send_read(COORD_W'(r + SCREEN_HEIGHT * $urandom_range(0, 7)));
            end else if (pick < 91) begin
                send_draw(COORD_W'($urandom), COORD_W'($urandom), ROFF_W'($urandom),
                          BYTE_W'($urandom), 1'($urandom));
            end else if (pick < 94) begin
                send_request(KIND_UNUSED, COORD_W'($urandom), COORD_W'($urandom),
                             ROFF_W'($urandom), BYTE_W'($urandom), 1'($urandom));
                request_count--;
            end else if (pick < 96) begin
                send_request(KIND_CLEAR, COORD_W'($urandom), COORD_W'($urandom),
                             ROFF_W'($urandom), BYTE_W'($urandom), 1'($urandom));
            end else begin
                // switch between idle-free stretches and random gaps
                sender_burst   = ($urandom_range(0, 2) == 0);
                receiver_eager = ($urandom_range(0, 2) == 0);
            end
        end
        sender_burst   = 1'b0;
        receiver_eager = 1'b0;
    endtask

    initial begin
        for (int r = 0; r < SCREEN_HEIGHT; r++)
            screen_rows[r] = '0;
        collide_latch  = 1'b0;
        error_count    = 0;
        request_count  = 0;
        result_count   = 0;
        stuck_cycles   = 0;
        sender_burst   = 1'b0;
        receiver_eager = 1'b0;
        hold_request   = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_blank_after_reset();
        test_basic_draw();
        test_collision();
        test_clipping();
        test_clear_and_unused();
        test_backpressure();
        test_random_traffic();
        wait_for_results();

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/sxf_pkg.sv
hw/rtl/sxf_ram.sv
hw/rtl/sprite_xor_framebuffer.sv
bench/tb_sprite_xor_framebuffer.sv
